// ----- hw/rtl/hwt_pkg.sv -----
// hwt_pkg: shared types and codes of the heartbeat watchdog table
// no dependencies; imported by hwt_ram users, hwt_out_reg and the top level
`timescale 1ns / 1ps

package hwt_pkg;

  // default number of table slots
  localparam int unsigned NODES_DEF = 16;

  // field widths
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned TMO_W     = 24;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // stream word widths (packed fields, padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = CFG_IDX_W'(1);

  // result kinds
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_REGISTER   = 3'd0,
    FN_UNREGISTER = 3'd1,
    FN_HEARTBEAT  = 3'd2,
    FN_QUERY      = 3'd3,
    FN_TICK       = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_FIN,
    S_SCAN,
    S_REPLY,
    S_SELECT,
    S_EVENT
  } state_e;

  // one result word
  typedef struct packed {
    logic            kind;
    status_e         status;
    logic            responsive;
    logic [ID_W-1:0] event_node;
    logic            last;
  } res_t;

endpackage

// ----- hw/rtl/hwt_ram.sv -----
// hwt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module hwt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/hwt_out_reg.sv -----
// hwt_out_reg: output register of the result stream, packs a result word
// depends on hwt_pkg
`timescale 1ns / 1ps

module hwt_out_reg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  hwt_pkg::res_t                     word_i,
  output logic                              ready_o,
  output logic                              tvalid_o,
  input  logic                              tready_i,
  output logic [hwt_pkg::OUT_DATA_W-1:0]    tdata_o,  // status, responsive, event_node
  output logic                              tlast_o,
  output logic                              tuser_o   // kind
);
  import hwt_pkg::*;

  logic vld_q, vld_d;
  res_t word_q;

  // free when empty or being drained this cycle
  assign ready_o = !vld_q || tready_i;

  always_comb begin
    vld_d = vld_q;
    if (tready_i) begin
      vld_d = 1'b0;
    end
    if (load_i) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign tvalid_o = vld_q;
  assign tdata_o  = {(OUT_DATA_W - STATUS_W - 1 - ID_W)'(0), word_q.event_node,
                     word_q.responsive, word_q.status};
  assign tlast_o  = word_q.last;
  assign tuser_o  = word_q.kind;

endmodule

// ----- hw/rtl/heartbeat_watchdog_table.sv -----
// heartbeat_watchdog_table: top level, table sequencer, time base and config registers
// depends on hwt_pkg, hwt_ram, hwt_out_reg
`timescale 1ns / 1ps

// Watchdog over a table of NODES monitored nodes. Each input word carries one
// operation (register, unregister, heartbeat, query, one millisecond tick) and
// yields one status reply; a tick that triggers a timeout scan then yields one
// timeout event per node that newly went unresponsive, in ascending node id
// order, the final word of the item flagged by tlast. Node id and timeout live
// in one ram, the last-heartbeat time in a second ram, both with a registered
// read; valid and responsive flags are flip-flops. Every lookup is a walk over
// all slots through the ram read port, used by a register, unregister,
// heartbeat or query; an unknown function, a rejected argument and a tick
// without scan need no walk. A scanning tick walks the table once to mark
// expired nodes and once more for each event to pick the smallest remaining
// id. The next word is taken once the item is done; the last result may still
// wait in the output register meanwhile. Configuration is to be written only
// while the block is idle, which the block itself does not enforce;
// cfg_ready_o is always high. The rams need no clearing after reset: slots are
// only read through valid flags, and ram accesses never overlap since writes
// happen only once a walk has drained.

module heartbeat_watchdog_table #(
  parameter int unsigned NODES = hwt_pkg::NODES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input words
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [hwt_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // func, node_id, timeout, checksum_ok
  // result words
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [hwt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // status, responsive, event_node
  output logic                             m_axis_tlast,
  output logic                             m_axis_tuser,  // kind
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hwt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hwt_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import hwt_pkg::*;

  localparam int unsigned IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] NODES_C = CW'(NODES);
  localparam int unsigned A_W = ID_W + TMO_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic                enable_q;
  logic [PERIOD_W-1:0] period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      period_q <= PERIOD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        default:    ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input field unpacking
  // ---------------------------------------------------------------------------
  logic [FUNC_W-1:0] in_func;
  logic [ID_W-1:0]   in_id;
  logic [TMO_W-1:0]  in_tmo;
  logic              in_csok;

  assign in_func = s_axis_tdata[FUNC_W-1:0];
  assign in_id   = s_axis_tdata[FUNC_W +: ID_W];
  assign in_tmo  = s_axis_tdata[FUNC_W+ID_W +: TMO_W];
  assign in_csok = s_axis_tdata[FUNC_W+ID_W+TMO_W];

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [FUNC_W-1:0]   func_q;
  logic [ID_W-1:0]     id_q;
  logic [TMO_W-1:0]    tmo_q;
  status_e             status_q;
  logic                resp_q;

  logic [TIME_W-1:0]   time_q;
  logic [PERIOD_W-1:0] pcount_q;

  logic [NODES-1:0]    valid_q;
  logic [NODES-1:0]    alive_q;
  logic [NODES-1:0]    hit_q;
  logic [CW-1:0]       hit_cnt_q;

  // walk counter and read pipeline
  logic [CW-1:0]       cnt_q;
  logic                pipe_vld_q;
  logic [IW-1:0]       pipe_idx_q;

  // lookup results
  logic                found_q;
  logic [IW-1:0]       found_slot_q;
  logic                free_q;
  logic [IW-1:0]       free_slot_q;

  // minimum search over pending events
  logic                min_vld_q;
  logic [ID_W-1:0]     min_id_q;
  logic [IW-1:0]       min_slot_q;

  // ---------------------------------------------------------------------------
  // rams
  // ---------------------------------------------------------------------------
  logic              issue;
  logic              walk_done;
  logic              a_we, b_we;
  logic [IW-1:0]     wr_slot;
  logic [A_W-1:0]    a_rdata;
  logic [TIME_W-1:0] b_rdata;
  logic [ID_W-1:0]   rd_node;
  logic [TMO_W-1:0]  rd_tmo;

  hwt_ram #(
    .WIDTH (A_W),
    .DEPTH (NODES)
  ) u_ram_id (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (wr_slot),
    .wdata_i ({tmo_q, id_q}),
    .re_i    (issue),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (a_rdata)
  );

  hwt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NODES)
  ) u_ram_beat (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (wr_slot),
    .wdata_i (time_q),
    .re_i    (issue),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (b_rdata)
  );

  assign rd_node = a_rdata[ID_W-1:0];
  assign rd_tmo  = a_rdata[ID_W +: TMO_W];

  // walk: one read issued per cycle, compared in the cycle after
  assign issue = ((state_q == S_LOOKUP) || (state_q == S_SCAN) || (state_q == S_SELECT))
                 && (cnt_q != NODES_C);
  assign walk_done = (cnt_q == NODES_C) && !pipe_vld_q;

  // elapsed time since last heartbeat, modular
  logic [TIME_W-1:0] elapsed;
  logic              expired;
  assign elapsed = time_q - b_rdata;
  assign expired = elapsed > {(TIME_W - TMO_W)'(0), rd_tmo};

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic out_ready;
  logic out_load;
  res_t out_word;

  hwt_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_load),
    .word_i   (out_word),
    .ready_o  (out_ready),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast),
    .tuser_o  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // tick timing
  // ---------------------------------------------------------------------------
  logic [PERIOD_W-1:0] period_eff;
  logic [PERIOD_W-1:0] pcount_inc;
  logic                scan_due;

  // a zero period behaves as one
  assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign pcount_inc = pcount_q + PERIOD_W'(1);
  assign scan_due   = enable_q && ((pcount_inc >= period_eff) || (pcount_inc == '0));

  // ---------------------------------------------------------------------------
  // sequencer: next state and control
  // ---------------------------------------------------------------------------
  logic accept;
  logic fin_reg_ok;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign fin_reg_ok = (func_q == FN_REGISTER) && !found_q && free_q;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    out_word      = '{kind: KIND_REPLY, status: status_q, responsive: resp_q,
                      event_node: '0, last: (hit_cnt_q == '0)};
    a_we          = 1'b0;
    b_we          = 1'b0;
    wr_slot       = fin_reg_ok ? free_slot_q : found_slot_q;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (in_func > FN_TICK) begin
            state_d = S_REPLY;
          end else if (in_func == FN_TICK) begin
            state_d = scan_due ? S_SCAN : S_REPLY;
          end else if ((in_func == FN_REGISTER) && (in_tmo == '0)) begin
            state_d = S_REPLY;
          end else if ((in_func == FN_HEARTBEAT) && !in_csok) begin
            state_d = S_REPLY;
          end else begin
            state_d = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        if (walk_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        a_we    = fin_reg_ok;
        b_we    = fin_reg_ok || ((func_q == FN_HEARTBEAT) && found_q);
        state_d = S_REPLY;
      end
      S_SCAN: begin
        if (walk_done) begin
          state_d = S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_ready) begin
          out_load = 1'b1;
          state_d  = (hit_cnt_q == '0) ? S_IDLE : S_SELECT;
        end
      end
      S_SELECT: begin
        if (walk_done) begin
          state_d = S_EVENT;
        end
      end
      S_EVENT: begin
        out_word = '{kind: KIND_EVENT, status: ST_OK, responsive: 1'b0,
                     event_node: min_id_q, last: (hit_cnt_q == CW'(1))};
        if (out_ready) begin
          out_load = 1'b1;
          state_d  = (hit_cnt_q == CW'(1)) ? S_IDLE : S_SELECT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath and table flags
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q     <= '0;
      pcount_q   <= '0;
      valid_q    <= '0;
      alive_q    <= '0;
      hit_q      <= '0;
      hit_cnt_q  <= '0;
      cnt_q      <= '0;
      pipe_vld_q <= 1'b0;
      found_q    <= 1'b0;
      free_q     <= 1'b0;
      min_vld_q  <= 1'b0;
    end else begin
      pipe_vld_q <= issue;
      if (issue) begin
        cnt_q <= cnt_q + CW'(1);
      end

      if (accept) begin
        cnt_q     <= '0;
        found_q   <= 1'b0;
        free_q    <= 1'b0;
        hit_q     <= '0;
        hit_cnt_q <= '0;
        if (in_func == FN_TICK) begin
          time_q <= time_q + TIME_W'(1);
          if (!enable_q || scan_due) begin
            pcount_q <= '0;
          end else begin
            pcount_q <= pcount_inc;
          end
        end
      end

      // lookup compare, lowest matching and lowest free slot
      if ((state_q == S_LOOKUP) && pipe_vld_q) begin
        if (valid_q[pipe_idx_q] && (rd_node == id_q) && !found_q) begin
          found_q <= 1'b1;
        end
        if (!valid_q[pipe_idx_q] && !free_q) begin
          free_q <= 1'b1;
        end
      end

      // timeout scan marks expired responsive nodes
      if ((state_q == S_SCAN) && pipe_vld_q) begin
        if (valid_q[pipe_idx_q] && alive_q[pipe_idx_q] && expired) begin
          alive_q[pipe_idx_q] <= 1'b0;
          hit_q[pipe_idx_q]   <= 1'b1;
          hit_cnt_q           <= hit_cnt_q + CW'(1);
        end
      end

      // write back of the item's effect
      if (state_q == S_FIN) begin
        if (fin_reg_ok) begin
          valid_q[free_slot_q] <= 1'b1;
          alive_q[free_slot_q] <= 1'b1;
        end else if (found_q && (func_q == FN_UNREGISTER)) begin
          valid_q[found_slot_q] <= 1'b0;
        end else if (found_q && (func_q == FN_HEARTBEAT)) begin
          alive_q[found_slot_q] <= 1'b1;
        end
      end

      // smallest pending id
      if ((state_q == S_SELECT) && pipe_vld_q && hit_q[pipe_idx_q]) begin
        if (!min_vld_q || (rd_node < min_id_q)) begin
          min_vld_q <= 1'b1;
        end
      end

      if (out_load) begin
        cnt_q     <= '0;
        min_vld_q <= 1'b0;
        if (state_q == S_EVENT) begin
          hit_q[min_slot_q] <= 1'b0;
          hit_cnt_q         <= hit_cnt_q - CW'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pipe_idx_q <= cnt_q[IW-1:0];

    if (accept) begin
      func_q   <= in_func;
      id_q     <= in_id;
      tmo_q    <= in_tmo;
      resp_q   <= 1'b0;
      status_q <= ST_OK;
      if (in_func > FN_TICK) begin
        status_q <= ST_INVALID;
      end else if ((in_func == FN_REGISTER) && (in_tmo == '0)) begin
        status_q <= ST_INVALID;
      end else if ((in_func == FN_HEARTBEAT) && !in_csok) begin
        status_q <= ST_INVALID;
      end
    end

    if ((state_q == S_LOOKUP) && pipe_vld_q) begin
      if (valid_q[pipe_idx_q] && (rd_node == id_q) && !found_q) begin
        found_slot_q <= pipe_idx_q;
      end
      if (!valid_q[pipe_idx_q] && !free_q) begin
        free_slot_q <= pipe_idx_q;
      end
    end

    if (state_q == S_FIN) begin
      if (func_q == FN_REGISTER) begin
        if (found_q) begin
          status_q <= ST_DUPLICATE;
        end else if (!free_q) begin
          status_q <= ST_FULL;
        end
      end else if (!found_q) begin
        status_q <= ST_NOT_FOUND;
      end else if (func_q == FN_QUERY) begin
        resp_q <= alive_q[found_slot_q];
      end
    end

    if ((state_q == S_SELECT) && pipe_vld_q && hit_q[pipe_idx_q]) begin
      if (!min_vld_q || (rd_node < min_id_q)) begin
        min_id_q   <= rd_node;
        min_slot_q <= pipe_idx_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // pending event count tracks the pending flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(hit_q) == 32'(hit_cnt_q))
    else $error("pending event count out of step with pending flags");

  // a timeout event always carries status ok and no responsive flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_EVENT)) |->
      (m_axis_tdata[STATUS_W-1:0] == ST_OK) && !m_axis_tdata[STATUS_W])
    else $error("timeout event with nonzero status or responsive flag");

  // a new registration occupies a free slot and marks it valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_we |-> !valid_q[wr_slot] ##1 valid_q[$past(wr_slot)])
    else $error("registration did not land in a free slot");

  // an event is only sent for a slot that was found by the minimum search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVENT) |-> min_vld_q && hit_q[min_slot_q])
    else $error("event without a pending slot selected");

endmodule

// ----- tb/heartbeat_watchdog_table_test.sv -----
// heartbeat_watchdog_table_test: self-checking bench for the heartbeat watchdog table
// drives directed and random operation words, predicts every reply and timeout event
// depends on hwt_pkg and heartbeat_watchdog_table
`timescale 1ns / 1ps

module heartbeat_watchdog_table_test;
  import hwt_pkg::*;

  localparam int unsigned SLOTS       = NODES_DEF;
  localparam int unsigned ID_POOL     = 24;          // ids that random traffic reuses
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = 2 * SLOTS;   // one table walk and some margin
  localparam int unsigned REPORT_MAX  = 200;         // keep a broken run readable

  // function codes that the block must reject
  localparam logic [FUNC_W-1:0] FN_UNDEF_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNDEF_LAST  = 3'd7;
  // register index past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(2);

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  // block ports, all inputs known from time zero
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // func, node_id, timeout, checksum_ok
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // status, responsive, event_node
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;        // kind
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DAT_W-1:0]  cfg_data_i    = '0;

  heartbeat_watchdog_table #(
    .NODES(SLOTS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the watchdog table, time base and scan registers
  // ---------------------------------------------------------------------------
  logic                 tbl_used  [SLOTS];
  logic [ID_W-1:0]      tbl_id    [SLOTS];
  logic [TMO_W-1:0]     tbl_tmo   [SLOTS];
  logic [TIME_W-1:0]    tbl_beat  [SLOTS];
  logic                 tbl_alive [SLOTS];
  logic [TIME_W-1:0]    now_ms;
  logic [PERIOD_W-1:0]  tick_count;
  logic                 scan_on;
  logic [PERIOD_W-1:0]  scan_period;

  // result words still owed by the block, oldest first
  res_t due_words [$];

  logic [ID_W-1:0] id_pool [ID_POOL];

  // run bookkeeping
  int unsigned errors      = 0;
  int unsigned words_in    = 0;
  int unsigned replies_out = 0;
  int unsigned events_out  = 0;
  int unsigned cycles      = 0;

  // idling control: calm turns off the random bursts on both sides
  bit calm       = 1'b0;
  int hold_req   = 0;   // long receiver hold requested by a test
  int stall_left = 0;

  res_t want;

  function automatic void clear_watchdog();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_id[i]    = '0;
      tbl_tmo[i]   = '0;
      tbl_beat[i]  = '0;
      tbl_alive[i] = 1'b0;
    end
    now_ms      = '0;
    tick_count  = '0;
    scan_on     = 1'b0;
    scan_period = PERIOD_RESET;
  endfunction

  function automatic int find_node(logic [ID_W-1:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_used[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void post_word(logic kind, status_e st, logic resp,
                                    logic [ID_W-1:0] node, logic last);
    res_t w;
    w.kind       = kind;
    w.status     = st;
    w.responsive = resp;
    w.event_node = node;
    w.last       = last;
    due_words.push_back(w);
  endfunction

  // applies one operation word to the shadow table and queues what it causes:
  // one status reply, then one event per node that just timed out, by id
  function automatic void apply_watchdog_op(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                                            logic [TMO_W-1:0] tmo, logic csok);
    status_e           st;
    logic              resp;
    int                slot;
    int                j;
    int                n_hits;
    logic [ID_W-1:0]   hits [SLOTS];
    logic [PERIOD_W-1:0] per;
    logic [TIME_W-1:0] elapsed;
    st     = ST_OK;
    resp   = 1'b0;
    slot   = -1;
    n_hits = 0;
    case (fn)
      FN_REGISTER: begin
        // zero timeout is refused before any lookup
        if (tmo == '0) st = ST_INVALID;
        else if (find_node(id) >= 0) st = ST_DUPLICATE;
        else begin
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!tbl_used[i]) slot = i;
          if (slot < 0) st = ST_FULL;
          else begin
            tbl_used[slot]  = 1'b1;
            tbl_id[slot]    = id;
            tbl_tmo[slot]   = tmo;
            tbl_beat[slot]  = now_ms;
            tbl_alive[slot] = 1'b1;
          end
        end
      end
      FN_UNREGISTER: begin
        slot = find_node(id);
        if (slot < 0) st = ST_NOT_FOUND;
        else tbl_used[slot] = 1'b0;
      end
      FN_HEARTBEAT: begin
        // a bad checksum is refused before the lookup
        if (!csok) st = ST_INVALID;
        else begin
          slot = find_node(id);
          if (slot < 0) st = ST_NOT_FOUND;
          else begin
            tbl_beat[slot]  = now_ms;
            tbl_alive[slot] = 1'b1;
          end
        end
      end
      FN_QUERY: begin
        slot = find_node(id);
        if (slot < 0) st = ST_NOT_FOUND;
        else resp = tbl_alive[slot];
      end
      FN_TICK: begin
        now_ms = now_ms + 1'b1;
        // the period counter is cleared while scans are off
        if (!scan_on) tick_count = '0;
        else begin
          per        = (scan_period == '0) ? PERIOD_W'(1) : scan_period;
          tick_count = tick_count + 1'b1;
          // a count at or past the period (or wrapped) triggers a scan
          if (tick_count >= per || tick_count == '0) begin
            tick_count = '0;
            for (int i = 0; i < SLOTS; i++) begin
              elapsed = now_ms - tbl_beat[i];
              if (tbl_used[i] && tbl_alive[i] && elapsed > TIME_W'(tbl_tmo[i])) begin
                tbl_alive[i] = 1'b0;
                j = n_hits;
                while (j > 0 && hits[j-1] > tbl_id[i]) begin
                  hits[j] = hits[j-1];
                  j--;
                end
                hits[j] = tbl_id[i];
                n_hits++;
              end
            end
          end
        end
      end
      default: st = ST_INVALID;
    endcase
    post_word(KIND_REPLY, st, resp, '0, n_hits == 0);
    for (int k = 0; k < n_hits; k++)
      post_word(KIND_EVENT, ST_OK, 1'b0, hits[k], k == n_hits - 1);
  endfunction

  // ---------------------------------------------------------------------------
  // input side: offers one word, predicts it once the block takes it
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                           logic [TMO_W-1:0] tmo, logic csok);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, csok, tmo, id, fn};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_watchdog_op(fn, id, tmo, csok);
    words_in++;
  endtask

  // stop offering and wait until everything owed has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // register write, only called once the block has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ENABLE) scan_on = val[0];
    else if (idx == CFG_PERIOD) scan_period = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic ticks(int n);
    for (int i = 0; i < n; i++) send_word(FN_TICK, $urandom, TMO_W'($urandom), 1'($urandom));
  endtask

  // one random word: mostly well-formed traffic on a small id pool so that
  // lookups hit, plus stray ids, bad checksums, zero timeouts and bad functions
  task automatic random_op();
    int                pick;
    logic [ID_W-1:0]   id;
    logic [TMO_W-1:0]  tmo;
    logic [FUNC_W-1:0] fn;
    pick = $urandom_range(0, 99);
    id   = ($urandom_range(0, 19) == 0) ? $urandom : id_pool[$urandom_range(0, ID_POOL - 1)];
    case ($urandom_range(0, 9))
      0:       tmo = '0;
      1, 2:    tmo = TMO_W'($urandom);
      default: tmo = TMO_W'($urandom_range(1, 30));
    endcase
    if (pick < 36) send_word(FN_TICK, $urandom, tmo, 1'($urandom));
    else if (pick < 54) send_word(FN_HEARTBEAT, id, tmo, $urandom_range(0, 7) != 0);
    else if (pick < 68) send_word(FN_REGISTER, id, tmo, 1'($urandom));
    else if (pick < 78) send_word(FN_UNREGISTER, id, tmo, 1'($urandom));
    else if (pick < 95) send_word(FN_QUERY, id, tmo, 1'($urandom));
    else begin
      fn = FUNC_W'($urandom_range(FN_UNDEF_FIRST, FN_UNDEF_LAST));
      send_word(fn, id, tmo, 1'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // rejected arguments and lookups in an empty table
  task automatic test_bad_args();
    send_word(FN_REGISTER, id_pool[0], '0, 1'b1);
    for (int f = FN_UNDEF_FIRST; f <= FN_UNDEF_LAST; f++)
      send_word(FUNC_W'(f), $urandom, TMO_W'($urandom), 1'b1);
    send_word(FN_QUERY, id_pool[0], '0, 1'b0);
    send_word(FN_UNREGISTER, id_pool[0], '0, 1'b0);
    send_word(FN_HEARTBEAT, id_pool[0], '0, 1'b1);
    send_word(FN_HEARTBEAT, id_pool[0], '0, 1'b0);
    drain();
  endtask

  // one node through its whole life, with the largest timeout
  task automatic test_node_life();
    send_word(FN_REGISTER, id_pool[1], '1, 1'b0);
    send_word(FN_REGISTER, id_pool[1], TMO_W'(5), 1'b1);
    send_word(FN_QUERY, id_pool[1], '0, 1'b0);
    send_word(FN_HEARTBEAT, id_pool[1], '0, 1'b0);
    send_word(FN_HEARTBEAT, id_pool[1], '0, 1'b1);
    send_word(FN_UNREGISTER, id_pool[1], '0, 1'b0);
    send_word(FN_QUERY, id_pool[1], '0, 1'b0);
    drain();
  endtask

  // full table, then one scan that times out every node at once
  task automatic test_full_table();
    for (int i = 0; i < SLOTS; i++) send_word(FN_REGISTER, id_pool[i], TMO_W'(1), 1'b1);
    send_word(FN_REGISTER, id_pool[SLOTS], TMO_W'(9), 1'b1);
    // duplicate wins over full
    send_word(FN_REGISTER, id_pool[3], TMO_W'(9), 1'b1);
    drain();
    write_reg(CFG_PERIOD, PERIOD_W'(1));
    write_reg(CFG_ENABLE, CFG_DAT_W'(1));
    ticks(2);
    send_word(FN_QUERY, id_pool[5], '0, 1'b0);
    send_word(FN_HEARTBEAT, id_pool[5], '0, 1'b1);
    send_word(FN_QUERY, id_pool[5], '0, 1'b0);
    drain();
  endtask

  // scan period handling: zero period, counter cleared while off, a period
  // lowered below the running count, the largest period, a stray index
  task automatic test_scan_period();
    write_reg(CFG_PERIOD, '0);
    ticks(3);
    drain();
    // only bit 0 of the enable word counts
    write_reg(CFG_ENABLE, 16'hFFFE);
    write_reg(CFG_PERIOD, PERIOD_W'(4));
    send_word(FN_HEARTBEAT, id_pool[7], '0, 1'b1);
    ticks(6);
    drain();
    write_reg(CFG_ENABLE, CFG_DAT_W'(1));
    send_word(FN_HEARTBEAT, id_pool[8], '0, 1'b1);
    ticks(4);
    drain();
    write_reg(CFG_PERIOD, PERIOD_W'(50));
    send_word(FN_HEARTBEAT, id_pool[9], '0, 1'b1);
    ticks(20);
    drain();
    write_reg(CFG_PERIOD, PERIOD_W'(8));
    ticks(1);
    drain();
    write_reg(CFG_PERIOD, '1);
    ticks(5);
    drain();
    write_reg(CFG_UNUSED, '1);
    ticks(2);
    drain();
  endtask

  // receiver holds off for a long time while words keep coming
  task automatic test_stall_input();
    calm     = 1'b1;
    hold_req = 400;
    for (int i = 0; i < 24; i++) random_op();
    calm = 1'b0;
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) random_op();
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, plus the long hold a test asks for
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req > 0) begin
      stall_left    <= hold_req - 1;
      hold_req       = 0;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void check_field(string what, logic [ID_W-1:0] want_v,
                                      logic [ID_W-1:0] got_v);
    if (got_v !== want_v) begin
      if (errors < REPORT_MAX)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
      errors++;
    end
  endfunction

  // compare every accepted result word with the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_words.size() == 0) begin
        if (errors < REPORT_MAX)
          $display("%0t: result word with nothing owed, expected none, got %h user %b last %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = due_words.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("status", want.status, m_axis_tdata[2:0]);
        check_field("responsive", want.responsive, m_axis_tdata[3]);
        check_field("event_node", want.event_node, m_axis_tdata[35:4]);
        check_field("last", want.last, m_axis_tlast);
      end
      if (m_axis_tuser == KIND_EVENT) events_out++;
      else replies_out++;
    end
  end

  // run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d words still owed", $time, due_words.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    clear_watchdog();
    // the first two pool ids are all-zero and all-one, the rest random
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < ID_POOL; i++) id_pool[i] = $urandom;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bad_args();
    test_node_life();
    test_full_table();
    test_scan_period();

    // random traffic under a few scan settings; the last part runs without idling
    for (int part = 0; part < 4; part++) begin
      write_reg(CFG_ENABLE, (part == 1) ? CFG_DAT_W'($urandom_range(0, 1)) : CFG_DAT_W'(1));
      write_reg(CFG_PERIOD, PERIOD_W'($urandom_range(1, 6)));
      if (part == 2) test_stall_input();
      if (part == 3) calm = 1'b1;
      test_random(66);
    end

    $display("covered %0d operation words giving %0d status replies and %0d timeout events,",
             words_in, replies_out, events_out);
    $display("full table, scan periods zero to maximum, scans off and a long output stall");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
